@@ rtl/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared constants and control types for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned VAL_W     = 32;   // input integer width
  localparam int unsigned WID_W     = 4;    // width field
  localparam int unsigned CHR_W     = 7;    // ASCII code width
  localparam int unsigned NUM_DIG   = 10;   // BCD digits of a 32-bit magnitude
  localparam int unsigned DIG_W     = 4 * NUM_DIG;
  localparam int unsigned CNT_W     = 4;    // character position / counts
  localparam int unsigned SHIFT_W   = 5;    // double-dabble step counter
  localparam int unsigned HEX_MAX_B = 4;    // hex byte count limit

  localparam logic [CHR_W-1:0] CHR_ZERO  = 7'h30;  // '0'
  localparam logic [CHR_W-1:0] CHR_UPA   = 7'h41;  // 'A'
  localparam logic [CHR_W-1:0] CHR_X     = 7'h78;  // 'x'
  localparam logic [CHR_W-1:0] CHR_MINUS = 7'h2D;  // '-'

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the input transfer
    logic shift;   // one double-dabble step
    logic count;   // work out digit, pad and total counts
    logic emit;    // load the next character into the output register
  } i2a_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hex;       // item is hex mode
    logic last_pos;  // current position is the final character
  } i2a_sts_t;

endpackage

@@ rtl/i2a_if.sv @@
// ----------------------------------------------------------------------------
// i2a_in_if / i2a_out_if
// Valid/ready channels for the formatter input item and result character.
// ----------------------------------------------------------------------------
interface i2a_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   action;
  logic signed [i2a_pkg::VAL_W-1:0]       value;
  logic        [i2a_pkg::WID_W-1:0]       width;

  modport source (output valid, output action, output value, output width, input ready);
  modport sink   (input valid, input action, input value, input width, output ready);
endinterface

interface i2a_out_if;
  logic                          valid;
  logic                          ready;
  logic [i2a_pkg::CHR_W-1:0]     char_code;
  logic                          last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ rtl/i2a_dp.sv @@
// ----------------------------------------------------------------------------
// i2a_dp
// Datapath: binary to BCD shifter, count logic and character output register.
// ----------------------------------------------------------------------------
module i2a_dp (
  input  logic                           clk,
  input  i2a_pkg::i2a_cmd_t              cmd,
  output i2a_pkg::i2a_sts_t              sts,
  input  logic                           in_action,
  input  logic [i2a_pkg::VAL_W-1:0]      in_value,
  input  logic [i2a_pkg::WID_W-1:0]      in_width,
  output logic [i2a_pkg::CHR_W-1:0]      out_char_code,
  output logic                           out_last
);

  logic                          act_r;
  logic                          neg_r;
  logic [i2a_pkg::WID_W-1:0]     wid_r;
  logic [i2a_pkg::VAL_W-1:0]     sh_r;
  logic [i2a_pkg::DIG_W-1:0]     dig_r;
  logic [i2a_pkg::CNT_W-1:0]     pre_end_r;
  logic [i2a_pkg::CNT_W-1:0]     pad_end_r;
  logic [i2a_pkg::CNT_W-1:0]     total_r;
  logic [i2a_pkg::CNT_W-1:0]     pos_r;
  logic [i2a_pkg::CHR_W-1:0]     char_r;
  logic                          last_r;

  logic [i2a_pkg::VAL_W-1:0]     mag;
  logic [i2a_pkg::DIG_W-1:0]     adj;
  logic [i2a_pkg::CNT_W-1:0]     lead_nd;
  logic [i2a_pkg::CNT_W-1:0]     nd_c;
  logic [i2a_pkg::CNT_W-1:0]     pre_c;
  logic [i2a_pkg::CNT_W-1:0]     nat_c;
  logic [i2a_pkg::CNT_W-1:0]     pad_c;
  logic [i2a_pkg::CNT_W-1:0]     hex_b;
  logic [i2a_pkg::CNT_W-1:0]     idx;
  logic [3:0]                    nib;
  logic [i2a_pkg::CHR_W-1:0]     char_c;

  assign mag = in_value[i2a_pkg::VAL_W-1] ? (~in_value + 32'd1) : in_value;

  // add-3 correction on every BCD digit
  always_comb begin
    for (int i = 0; i < i2a_pkg::NUM_DIG; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? (dig_r[4*i +: 4] + 4'd3)
                                                 : dig_r[4*i +: 4];
    end
  end

  // digits up to the highest nonzero one, at least one
  always_comb begin
    lead_nd = 4'd1;
    for (int i = 1; i < i2a_pkg::NUM_DIG; i++) begin
      if (dig_r[4*i +: 4] != 4'd0) lead_nd = i[i2a_pkg::CNT_W-1:0] + 4'd1;
    end
  end

  always_comb begin
    hex_b = (wid_r > 4'(i2a_pkg::HEX_MAX_B)) ? 4'(i2a_pkg::HEX_MAX_B) : wid_r;
    if (act_r && (wid_r != 4'd0)) nd_c = {hex_b[2:0], 1'b0};
    else                          nd_c = lead_nd;
    if (act_r)      pre_c = 4'd2;
    else if (neg_r) pre_c = 4'd1;
    else            pre_c = 4'd0;
    nat_c = nd_c + pre_c;
    if (!act_r && (wid_r > nat_c)) pad_c = wid_r - nat_c;
    else                           pad_c = 4'd0;
  end

  // character at the current position
  always_comb begin
    idx = total_r - 4'd1 - pos_r;
    nib = (idx < 4'(i2a_pkg::NUM_DIG)) ? dig_r[{idx, 2'b00} +: 4] : 4'd0;
    if (pos_r < pre_end_r) begin
      if (!act_r)              char_c = i2a_pkg::CHR_MINUS;
      else if (pos_r == 4'd0)  char_c = i2a_pkg::CHR_ZERO;
      else                     char_c = i2a_pkg::CHR_X;
    end else if (pos_r < pad_end_r) begin
      char_c = i2a_pkg::CHR_ZERO;
    end else if (nib <= 4'd9) begin
      char_c = i2a_pkg::CHR_ZERO + {3'b000, nib};
    end else begin
      char_c = i2a_pkg::CHR_UPA + {3'b000, nib} - 7'd10;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      neg_r <= in_value[i2a_pkg::VAL_W-1];
      wid_r <= in_width;
      sh_r  <= mag;
      dig_r <= in_action ? {8'h00, in_value} : '0;
    end else if (cmd.shift) begin
      dig_r <= {adj[i2a_pkg::DIG_W-2:0], sh_r[i2a_pkg::VAL_W-1]};
      sh_r  <= {sh_r[i2a_pkg::VAL_W-2:0], 1'b0};
    end
    if (cmd.count) begin
      pre_end_r <= pre_c;
      pad_end_r <= pre_c + pad_c;
      total_r   <= pre_c + pad_c + nd_c;
      pos_r     <= 4'd0;
    end else if (cmd.emit) begin
      pos_r <= pos_r + 4'd1;
    end
    if (cmd.emit) begin
      char_r <= char_c;
      last_r <= sts.last_pos;
    end
  end

  assign sts.hex      = act_r;
  assign sts.last_pos = (pos_r == (total_r - 4'd1));

  assign out_char_code = char_r;
  assign out_last      = last_r;

endmodule

@@ rtl/i2a_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2a_ctrl
// Controller: sequences load, BCD conversion, counting and character output.
// ----------------------------------------------------------------------------
module i2a_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2a_pkg::i2a_cmd_t     cmd,
  input  i2a_pkg::i2a_sts_t     sts
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_COUNT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [i2a_pkg::SHIFT_W-1:0]   cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.hex) begin
          state_nxt = ST_COUNT;
        end else begin
          cmd.shift = 1'b1;
          cnt_nxt   = cnt_r + 5'd1;
          if (cnt_r == '1) state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.last_pos) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CONV))
    else $error("accepted item did not start conversion");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last_pos) |=> (state_r == ST_IDLE))
    else $error("final character did not end the item");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("output valid raised outside emit");

  a_full_conversion: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COUNT && !sts.hex) |-> (cnt_r == '0))
    else $error("decimal conversion ended early");
`endif

endmodule

@@ rtl/integer_to_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a 32-bit integer as signed decimal or 0x-prefixed hex ASCII text,
// one character per output transfer, with last on the final character.
// ----------------------------------------------------------------------------
// Sequence: a decimal item goes through load, 32 shift steps of the BCD converter
//   and count before its first character; a hex item skips the shift steps.
// Throughput: one character per cycle once started, while the receiver holds
//   ready high; an item has up to 15 characters, and items do not overlap.
// Reset: synchronous active-low rst_n returns the controller to idle and
//   drops out valid; datapath registers are not reset.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic       clk,
  input  logic       rst_n,
  i2a_in_if.sink     in_ch,
  i2a_out_if.source  out_ch
);

  i2a_pkg::i2a_cmd_t cmd;   // controller commands
  i2a_pkg::i2a_sts_t sts;   // datapath status

  // Controller: one item at a time; input ready only while idle, but the
  // last character of the previous item may still sit in the output register.
  i2a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: double-dabble shifter for decimal, direct nibble load for hex,
  // then a position counter walks prefix, zero pad and digits.
  i2a_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_ch.action),
    .in_value      (in_ch.value),
    .in_width      (in_ch.width),
    .out_char_code (out_ch.char_code),
    .out_last      (out_ch.last)
  );

endmodule

@@ bench/tb_integer_to_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter
// Self-checking bench for the integer to ASCII formatter. Numbers go in on
// the input channel. A text predictor builds the characters each number
// should produce, and each output transfer is checked against the oldest
// character still outstanding. Directed decimal and hex corner cases run
// first, then a long output stall, then random numbers under three idle
// profiles on the two channels.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  import i2a_pkg::*;

  // action encodings on the input channel
  localparam logic ACT_DEC = 1'b0;
  localparam logic ACT_HEX = 1'b1;

  // ASCII codes the predictor builds text from
  localparam logic [CHR_W-1:0] ASC_ZERO  = 7'h30;
  localparam logic [CHR_W-1:0] ASC_UPA   = 7'h41;
  localparam logic [CHR_W-1:0] ASC_X     = 7'h78;
  localparam logic [CHR_W-1:0] ASC_MINUS = 7'h2D;

  localparam int DRAIN_CYCLES = 40;   // outlasts a decimal item's conversion
  localparam int STALL_CYCLES = 300;  // long receiver hold-off

  typedef struct packed {
    logic [CHR_W-1:0] code;
    logic             last;
  } text_char_t;

  logic clk;
  logic rst_n;

  i2a_in_if  in_ch ();
  i2a_out_if out_ch ();

  integer_to_ascii_formatter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Characters still owed by the block, oldest first.
  text_char_t pending_text[$];
  int         mismatch_count = 0;

  // Idle profile, in percent of cycles; changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Cycles left in a forced receiver hold-off.
  int recv_hold_left = 0;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops characters.
  initial begin
    #5ms;
    $display("integer_to_ascii_formatter: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Text predictor: appends the expected characters of one number.
  // --------------------------------------------------------------------------
  function automatic logic [CHR_W-1:0] hex_digit_char(input logic [3:0] d);
    if (d <= 4'd9) return ASC_ZERO + CHR_W'(d);
    else           return ASC_UPA + CHR_W'(d - 4'd10);
  endfunction

  function automatic void predict_text(input logic act, input logic [31:0] val,
                                       input logic [3:0] wid);
    logic [CHR_W-1:0] txt[$];
    logic [3:0]       digs[10];
    logic [31:0]      mag;
    logic             neg;
    int               nd;
    int               pad;
    text_char_t       tc;

    if (act == ACT_DEC) begin
      neg = val[31];
      // most negative value: two's complement negate leaves 0x80000000,
      // which read unsigned is the right magnitude
      mag = neg ? (32'd0 - val) : val;
      nd = 0;
      do begin
        digs[nd] = 4'(mag % 10);
        nd++;
        mag = mag / 10;
      end while (mag != 0 && nd < 10);
      // sign counts toward the width; padding goes between sign and digits
      pad = (int'(wid) > nd + int'(neg)) ? int'(wid) - nd - int'(neg) : 0;
      if (neg) txt.push_back(ASC_MINUS);
      repeat (pad) txt.push_back(ASC_ZERO);
      for (int i = nd - 1; i >= 0; i--) txt.push_back(ASC_ZERO + CHR_W'(digs[i]));
    end else begin
      txt.push_back(ASC_ZERO);
      txt.push_back(ASC_X);
      if (wid == 4'd0) begin
        // minimal digit count; zero still shows one digit
        nd = 8;
        while (nd > 1 && val[(nd-1)*4 +: 4] == 4'd0) nd--;
      end else begin
        // two digits per byte, byte count clipped at four
        nd = 2 * ((wid > 4'd4) ? 4 : int'(wid));
      end
      for (int i = nd - 1; i >= 0; i--) txt.push_back(hex_digit_char(val[i*4 +: 4]));
    end

    foreach (txt[i]) begin
      tc.code = txt[i];
      tc.last = (i == txt.size() - 1);
      pending_text.push_back(tc);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offers one number, waits for its transfer. Called at a falling
  // edge and returns at a falling edge with valid still high, so back-to-back
  // numbers need no drop of valid.
  // --------------------------------------------------------------------------
  task automatic send_number(input logic act, input logic [31:0] val,
                             input logic [3:0] wid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.action = act;
    in_ch.value  = val;
    in_ch.width  = wid;
    do @(posedge clk); while (!in_ch.ready);
    predict_text(act, val, wid);
    @(negedge clk);
  endtask

  // Sender pause: nothing offered until every owed character has arrived,
  // then enough cycles for a number in flight to finish.
  task automatic wait_text_drained();
    in_ch.valid = 1'b0;
    while (pending_text.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready pattern set at each falling edge. A forced hold-off
  // overrides the random idling.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_left > 0) begin
        out_ch.ready = 1'b0;
        recv_hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: each character transfer against the oldest owed character.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character code=%h last=%b", $time,
                 out_ch.char_code, out_ch.last);
        mismatch_count++;
      end else begin
        want = pending_text.pop_front();
        if (out_ch.char_code !== want.code) begin
          $display("%0t: char_code expected %h actual %h", $time,
                   want.code, out_ch.char_code);
          mismatch_count++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time,
                   want.last, out_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random number source: mixes full-range patterns with small and extreme
  // values so that all digit counts and both signs come up often.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(999);
      2: v = 32'd0 - $urandom_range(1, 999);
      3: case ($urandom_range(3))
           0: v = 32'h0000_0000;
           1: v = 32'h7FFF_FFFF;
           2: v = 32'h8000_0000;
           default: v = 32'hFFFF_FFFF;
         endcase
      4: begin
        v = 32'd1 << $urandom_range(31);
        if ($urandom_range(1)) v = ~v;
      end
      default: v = $urandom >> $urandom_range(31);
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Decimal: sign, zero, both extremes, padding above/at/below natural length.
  task automatic test_decimal_corners();
    send_number(ACT_DEC, 32'd0, 4'd0);
    send_number(ACT_DEC, 32'd1, 4'd0);
    send_number(ACT_DEC, 32'hFFFF_FFFF, 4'd0);          // -1
    send_number(ACT_DEC, 32'h7FFF_FFFF, 4'd0);          // largest positive
    send_number(ACT_DEC, 32'h8000_0000, 4'd0);          // most negative
    send_number(ACT_DEC, 32'h8000_0000, 4'd15);         // padded, 15 chars
    send_number(ACT_DEC, 32'h7FFF_FFFF, 4'd15);
    send_number(ACT_DEC, 32'd0 - 32'd5, 4'd15);         // zeros after the sign
    send_number(ACT_DEC, 32'd7, 4'd1);                  // width equal to length
    send_number(ACT_DEC, 32'd123, 4'd3);                // width equal to length
    send_number(ACT_DEC, 32'd0 - 32'd123, 4'd4);        // sign counts in width
    send_number(ACT_DEC, 32'd0 - 32'd123, 4'd5);
    wait_text_drained();
  endtask

  // Hex: minimal width incl. zero, each fixed byte count, clipping above four.
  task automatic test_hex_corners();
    send_number(ACT_HEX, 32'h0000_0000, 4'd0);          // gives 0x0
    send_number(ACT_HEX, 32'h0000_0000, 4'd1);
    send_number(ACT_HEX, 32'hFFFF_FFFF, 4'd0);
    send_number(ACT_HEX, 32'h8000_0000, 4'd0);
    send_number(ACT_HEX, 32'h0000_ABCD, 4'd0);
    send_number(ACT_HEX, 32'h0000_0010, 4'd0);
    send_number(ACT_HEX, 32'h1234_5678, 4'd1);          // high digits dropped
    send_number(ACT_HEX, 32'h1234_5678, 4'd2);
    send_number(ACT_HEX, 32'h1234_5678, 4'd3);
    send_number(ACT_HEX, 32'h9ABC_DEF0, 4'd4);
    send_number(ACT_HEX, 32'h9ABC_DEF0, 4'd5);          // clipped to four bytes
    send_number(ACT_HEX, 32'h9ABC_DEF0, 4'd15);
    wait_text_drained();
  endtask

  // Receiver stalls for a long stretch while numbers keep coming, so the
  // block backs up and holds off the input channel.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    recv_hold_left = STALL_CYCLES;
    @(negedge clk);
    for (int i = 0; i < 8; i++)
      send_number($urandom_range(1), random_value(), 4'($urandom_range(15)));
    wait_text_drained();
  endtask

  task automatic test_random_numbers(input int count, input int send_pct,
                                     input int recv_pct);
    logic [3:0] wid;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      // favor the hex byte counts that matter, but keep the full range
      wid = ($urandom_range(2) == 0) ? 4'($urandom_range(5)) : 4'($urandom_range(15));
      send_number($urandom_range(1), random_value(), wid);
    end
    wait_text_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_DEC;
    in_ch.value  = '0;
    in_ch.width  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_decimal_corners();
    test_hex_corners();
    test_output_stall();
    test_random_numbers(170, 30, 55);
    test_random_numbers(170, 55, 30);
    test_random_numbers(160, 0, 0);

    in_ch.valid = 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_text.size() == 0) begin
      $display("integer_to_ascii_formatter: match");
    end else begin
      $display("integer_to_ascii_formatter: mismatch");
    end
    $finish;
  end

endmodule
